### src/lidar_point_georeference_assert.svh
// Assertion macros for the checker file of the georeference block.
`ifndef LIDAR_POINT_GEOREFERENCE_ASSERT_SVH
`define LIDAR_POINT_GEOREFERENCE_ASSERT_SVH

// Property checked at every rising clock edge, reset included.
`define LPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked at rising clock edges outside reset.
`define LPG_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### src/lpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpg_pkg;

  // Q30 one and the factor from hundredths of a degree to Q30 radians.
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [17:0] RAD_K = 18'd187403;

  // Horner steps of the sine series and the widths of the Horner divide.
  localparam logic [2:0] HORNER_LAST = 3'd4;
  localparam int DIV_W = 32;
  localparam int DVS_W = 7;

  // Sine and cosine slots, the two pitch-roll products and the unit constant.
  localparam logic [3:0] V_SR = 4'd0;
  localparam logic [3:0] V_CR = 4'd1;
  localparam logic [3:0] V_SP = 4'd2;
  localparam logic [3:0] V_CP = 4'd3;
  localparam logic [3:0] V_SY = 4'd4;
  localparam logic [3:0] V_CY = 4'd5;
  localparam logic [3:0] V_SPSR = 4'd6;
  localparam logic [3:0] V_SPCR = 4'd7;
  localparam logic [3:0] V_ONE = 4'd8;

  localparam logic [2:0] SIN_LAST = 3'd5;
  localparam logic [3:0] MOP_LAST = 4'd14;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    OPS_FK, OPS_XX, OPS_X2T, OPS_XT, OPS_VAL, OPS_PT
  } opsel_t;

  // What is done with a product in the cycle after its multiply command.
  typedef enum logic [2:0] {
    POST_NONE, POST_X, POST_X2, POST_DIV, POST_SIN, POST_MAT, POST_PT
  } post_t;

  // One step of the matrix build.
  typedef struct packed {
    logic [3:0] a_sel;
    logic [3:0] b_sel;
    logic       neg;
    logic       accum;
    logic       wr_mat;
    logic       to_val;
    logic [3:0] dst;
  } mop_t;

  typedef struct packed {
    logic       mul_go;
    opsel_t     opsel;
    post_t      post;
    logic       in_load;
    logic       ang_load;
    logic       t_init;
    logic [2:0] sin_idx;
    logic [2:0] hstep;
    logic [3:0] mop_idx;
    logic [1:0] prow;
    logic [1:0] pcol;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  // Divisors of the Horner series, innermost term first.
  function automatic logic [DVS_W-1:0] horner_div(input logic [2:0] idx);
    logic [DVS_W-1:0] d;
    case (idx)
      3'd0: d = 7'd110;
      3'd1: d = 7'd72;
      3'd2: d = 7'd42;
      3'd3: d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // Product sequence that builds the nine matrix entries.
  function automatic mop_t mop_entry(input logic [3:0] idx);
    mop_t m;
    m = '0;
    case (idx)
      4'd0: begin
        m.a_sel = V_SP; m.b_sel = V_SR; m.to_val = 1'b1; m.dst = V_SPSR;
      end
      4'd1: begin
        m.a_sel = V_SP; m.b_sel = V_CR; m.to_val = 1'b1; m.dst = V_SPCR;
      end
      4'd2: begin
        m.a_sel = V_CY; m.b_sel = V_CP; m.wr_mat = 1'b1; m.dst = 4'd0;
      end
      4'd3: begin
        m.a_sel = V_SY; m.b_sel = V_CR; m.neg = 1'b1;
      end
      4'd4: begin
        m.a_sel = V_CY; m.b_sel = V_SPSR; m.accum = 1'b1; m.wr_mat = 1'b1; m.dst = 4'd1;
      end
      4'd5: begin
        m.a_sel = V_SY; m.b_sel = V_SR;
      end
      4'd6: begin
        m.a_sel = V_CY; m.b_sel = V_SPCR; m.accum = 1'b1; m.wr_mat = 1'b1; m.dst = 4'd2;
      end
      4'd7: begin
        m.a_sel = V_SY; m.b_sel = V_CP; m.wr_mat = 1'b1; m.dst = 4'd3;
      end
      4'd8: begin
        m.a_sel = V_CY; m.b_sel = V_CR;
      end
      4'd9: begin
        m.a_sel = V_SY; m.b_sel = V_SPSR; m.accum = 1'b1; m.wr_mat = 1'b1; m.dst = 4'd4;
      end
      4'd10: begin
        m.a_sel = V_SY; m.b_sel = V_SPCR;
      end
      4'd11: begin
        m.a_sel = V_CY; m.b_sel = V_SR; m.neg = 1'b1; m.accum = 1'b1;
        m.wr_mat = 1'b1; m.dst = 4'd5;
      end
      4'd12: begin
        m.a_sel = V_SP; m.b_sel = V_ONE; m.neg = 1'b1; m.wr_mat = 1'b1; m.dst = 4'd6;
      end
      4'd13: begin
        m.a_sel = V_CP; m.b_sel = V_SR; m.wr_mat = 1'b1; m.dst = 4'd7;
      end
      4'd14: begin
        m.a_sel = V_CP; m.b_sel = V_CR; m.wr_mat = 1'b1; m.dst = 4'd8;
      end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

### src/lpg_cdiv.sv
`timescale 1ns / 1ps
`default_nettype none
module lpg_cdiv (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [lpg_pkg::DIV_W-1:0]     dividend,
  input  wire logic [lpg_pkg::DVS_W-1:0]     divisor,
  output logic      [lpg_pkg::DIV_W-1:0]     quotient,
  output logic                               done
);
  import lpg_pkg::*;

  localparam int NSH_W = DIV_W - 1;
  localparam int RCP_W = 32;
  localparam int PRD_W = NSH_W + RCP_W;

  logic             mul_v;
  logic [NSH_W-1:0] n_sh;
  logic [RCP_W-1:0] rcp;
  logic [5:0]       sft;
  logic [PRD_W-1:0] prd;
  logic [NSH_W-1:0] n_sel;
  logic [RCP_W-1:0] rcp_sel;
  logic [5:0]       sft_sel;

  // Each divisor is a power of two times an odd factor. The power of two is
  // shifted out first, then the dividend is multiplied by the rounded-up
  // reciprocal of the odd factor, which is exact for 31-bit dividends.
  always_comb begin
    case (divisor)
      7'd110: begin
        n_sel = dividend[DIV_W-1:1]; rcp_sel = 32'd2498890064; sft_sel = 6'd37;
      end
      7'd72: begin
        n_sel = {2'd0, dividend[DIV_W-1:3]}; rcp_sel = 32'd3817748708; sft_sel = 6'd35;
      end
      7'd42: begin
        n_sel = dividend[DIV_W-1:1]; rcp_sel = 32'd3272356036; sft_sel = 6'd36;
      end
      7'd20: begin
        n_sel = {1'b0, dividend[DIV_W-1:2]}; rcp_sel = 32'd3435973837; sft_sel = 6'd34;
      end
      default: begin
        n_sel = dividend[DIV_W-1:1]; rcp_sel = 32'd2863311531; sft_sel = 6'd33;
      end
    endcase
  end

  // Control: the product is formed in the cycle after start, done follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
      done <= 1'b0;
    end else begin
      mul_v <= start;
      done <= mul_v;
    end
  end

  // Data: operands are captured at start, then multiplied.
  always_ff @(posedge clk) begin
    if (start) begin
      n_sh <= n_sel;
      rcp <= rcp_sel;
      sft <= sft_sel;
    end
    if (mul_v) begin
      prd <= n_sh * rcp;
    end
  end

  assign quotient = DIV_W'(prd >> sft);

endmodule
`default_nettype wire

### src/lpg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lpg_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lpg_pkg::cmd_t       cmd,
  output lpg_pkg::stat_t           stat,
  input  wire logic                operation,
  input  wire logic signed [15:0]  roll_angle,
  input  wire logic signed [15:0]  pitch_angle,
  input  wire logic signed [16:0]  yaw_angle,
  input  wire logic signed [31:0]  offset_north,
  input  wire logic signed [31:0]  offset_east,
  input  wire logic signed [31:0]  offset_down,
  input  wire logic signed [23:0]  body_x,
  input  wire logic signed [23:0]  body_y,
  input  wire logic signed [23:0]  body_z,
  output logic signed [31:0]       ned_x,
  output logic signed [31:0]       ned_y,
  output logic signed [31:0]       ned_z
);
  import lpg_pkg::*;

  localparam logic [17:0] TURN1 = 18'd36000;
  localparam logic [17:0] TURN2 = 18'd72000;
  localparam logic [17:0] TURN3 = 18'd108000;
  localparam logic [17:0] TURN4 = 18'd144000;
  localparam logic [15:0] QUART1 = 16'd9000;
  localparam logic [15:0] QUART2 = 16'd18000;
  localparam logic [15:0] QUART3 = 16'd27000;
  localparam logic signed [17:0] Q16_ONE = 18'sd65536;
  localparam logic signed [65:0] HALF16 = 66'sd32768;
  localparam logic signed [43:0] HALF16_PT = 44'sd32768;
  localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
  localparam logic signed [33:0] SAT_LO = -34'sd2147483648;
  localparam logic signed [19:0] SAT18_HI = 20'sd131071;
  localparam logic signed [19:0] SAT18_LO = -20'sd131072;

  cmd_t cmd_q;

  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic signed [16:0] yaw;
  logic signed [31:0] pos_off [3];
  logic signed [23:0] body [3];
  logic signed [17:0] mat [9];
  logic signed [17:0] val [8];

  logic [13:0]        f_reg;
  logic               neg_reg;
  logic [30:0]        x;
  logic [31:0]        x2;
  logic [30:0]        t;
  logic signed [65:0] prod;
  logic signed [19:0] acc;
  logic signed [43:0] pacc;
  logic signed [31:0] res [3];

  // Angle of the current sine, folded into the first quadrant.
  logic signed [16:0] ang;
  logic signed [17:0] ang_sh;
  logic signed [18:0] ang_b;
  logic [17:0]        r0;
  logic [15:0]        r1;
  logic [1:0]         quad;
  logic [15:0]        fr;
  logic [13:0]        f_fold;

  always_comb begin
    case (cmd.sin_idx[2:1])
      2'd0: ang = 17'(roll);
      2'd1: ang = 17'(pitch);
      default: ang = yaw;
    endcase
    ang_sh = 18'(ang) + (cmd.sin_idx[0] ? 18'sd9000 : 18'sd0);
    ang_b = 19'(ang_sh) + 19'sd72000;
    r0 = ang_b[17:0];
    if (r0 >= TURN4) r1 = 16'(r0 - TURN4);
    else if (r0 >= TURN3) r1 = 16'(r0 - TURN3);
    else if (r0 >= TURN2) r1 = 16'(r0 - TURN2);
    else if (r0 >= TURN1) r1 = 16'(r0 - TURN1);
    else r1 = r0[15:0];
    if (r1 >= QUART3) begin
      quad = 2'd3; fr = r1 - QUART3;
    end else if (r1 >= QUART2) begin
      quad = 2'd2; fr = r1 - QUART2;
    end else if (r1 >= QUART1) begin
      quad = 2'd1; fr = r1 - QUART1;
    end else begin
      quad = 2'd0; fr = r1;
    end
    f_fold = quad[0] ? 14'(QUART1 - fr) : fr[13:0];
  end

  // Operands of the shared multiplier.
  mop_t               mop_i;
  mop_t               mop_q;
  logic signed [17:0] val_a;
  logic signed [17:0] val_b;
  logic [3:0]         mat_i;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;

  always_comb begin
    mop_i = mop_entry(cmd.mop_idx);
    mop_q = mop_entry(cmd_q.mop_idx);
    val_a = (mop_i.a_sel == V_ONE) ? Q16_ONE : val[mop_i.a_sel[2:0]];
    val_b = (mop_i.b_sel == V_ONE) ? Q16_ONE : val[mop_i.b_sel[2:0]];
    mat_i = 4'(cmd.prow) * 4'd3 + 4'(cmd.pcol);
    case (cmd.opsel)
      OPS_FK: begin
        mul_a = {19'd0, f_reg}; mul_b = {15'd0, RAD_K};
      end
      OPS_XX: begin
        mul_a = {2'd0, x}; mul_b = {2'd0, x};
      end
      OPS_X2T: begin
        mul_a = {1'b0, x2}; mul_b = {2'd0, t};
      end
      OPS_XT: begin
        mul_a = {2'd0, x}; mul_b = {2'd0, t};
      end
      OPS_VAL: begin
        mul_a = 33'(val_a); mul_b = 33'(val_b);
      end
      OPS_PT: begin
        mul_a = 33'(mat[mat_i]); mul_b = 33'(body[cmd.pcol]);
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  // Divider by the Horner constants.
  logic              div_start;
  logic [DIV_W-1:0]  quotient;
  logic              div_done;
  logic [31:0]       t_sub;

  assign div_start = (cmd_q.post == POST_DIV);

  lpg_cdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[61:30]),
    .divisor  (horner_div(cmd_q.hstep)),
    .quotient (quotient),
    .done     (div_done)
  );

  assign stat.div_done = div_done;
  assign t_sub = Q30_ONE - quotient;

  // Rounding of the finished sine, of matrix terms and of point rows.
  logic [32:0]        s_sum;
  logic signed [17:0] sin_mag;
  logic signed [17:0] sin_val;
  logic signed [65:0] m_rnd;
  logic signed [19:0] m_term;
  logic signed [19:0] m_sum;
  logic signed [17:0] m_sat;
  logic signed [43:0] p_sum;
  logic signed [43:0] p_rnd;
  logic signed [33:0] p_tot;
  logic signed [31:0] p_sat;

  always_comb begin
    s_sum = {1'b0, prod[61:30]} + 33'd8192;
    sin_mag = s_sum[31:14];
    sin_val = neg_reg ? -sin_mag : sin_mag;

    m_rnd = (prod + HALF16) >>> 16;
    m_term = mop_q.neg ? -m_rnd[19:0] : m_rnd[19:0];
    m_sum = mop_q.accum ? acc + m_term : m_term;
    if (m_sum > SAT18_HI) m_sat = 18'sh1ffff;
    else if (m_sum < SAT18_LO) m_sat = 18'sh20000;
    else m_sat = m_sum[17:0];

    p_sum = (cmd_q.pcol == 2'd0) ? prod[43:0] : pacc + prod[43:0];
    p_rnd = (p_sum + HALF16_PT) >>> 16;
    p_tot = 34'($signed(p_rnd[27:0])) + 34'(pos_off[cmd_q.prow]);
    if (p_tot > SAT_HI) p_sat = 32'sh7fffffff;
    else if (p_tot < SAT_LO) p_sat = 32'sh80000000;
    else p_sat = p_tot[31:0];
  end

  // Command delay that lines post steps up with their product.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd;
    end
  end

  // Stored pose: matrix and offset, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) mat[i] <= '0;
      for (int i = 0; i < 3; i++) pos_off[i] <= '0;
    end else begin
      if (cmd.in_load && operation) begin
        pos_off[0] <= offset_north;
        pos_off[1] <= offset_east;
        pos_off[2] <= offset_down;
      end
      if (cmd_q.post == POST_MAT && mop_q.wr_mat) begin
        mat[mop_q.dst] <= m_sat;
      end
    end
  end

  // Working registers of the sine, matrix and point sequences.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      if (operation) begin
        roll <= roll_angle;
        pitch <= pitch_angle;
        yaw <= yaw_angle;
      end else begin
        body[0] <= body_x;
        body[1] <= body_y;
        body[2] <= body_z;
      end
    end
    if (cmd.ang_load) begin
      f_reg <= f_fold;
      neg_reg <= quad[1];
    end
    if (cmd.mul_go) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.t_init) begin
      t <= Q30_ONE[30:0];
    end else if (div_done) begin
      t <= t_sub[30:0];
    end
    case (cmd_q.post)
      POST_X: x <= prod[30:0];
      POST_X2: x2 <= prod[61:30];
      POST_SIN: val[cmd_q.sin_idx] <= sin_val;
      POST_MAT: begin
        acc <= m_sum;
        if (mop_q.to_val) val[mop_q.dst[2:0]] <= m_sum[17:0];
      end
      POST_PT: begin
        pacc <= p_sum;
        if (cmd_q.pcol == AXIS_LAST) res[cmd_q.prow] <= p_sat;
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      ned_x <= res[0];
      ned_y <= res[1];
      ned_z <= res[2];
    end
  end

endmodule
`default_nettype wire

### src/lpg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lpg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           operation,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lpg_pkg::cmd_t       cmd,
  input  wire lpg_pkg::stat_t stat
);
  import lpg_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_ANG    = 16'h0002,
    S_FK     = 16'h0004,
    S_XW     = 16'h0008,
    S_XX     = 16'h0010,
    S_X2W    = 16'h0020,
    S_HMUL   = 16'h0040,
    S_HW     = 16'h0080,
    S_DIVW   = 16'h0100,
    S_SMUL   = 16'h0200,
    S_SW     = 16'h0400,
    S_MOP    = 16'h0800,
    S_MDRAIN = 16'h1000,
    S_PMUL   = 16'h2000,
    S_PDRAIN = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] sk;
  logic [2:0] sk_next;
  logic [2:0] hcnt;
  logic [2:0] hcnt_next;
  logic [3:0] cnt;
  logic [3:0] cnt_next;
  logic [1:0] prow;
  logic [1:0] prow_next;
  logic [1:0] pcol;
  logic [1:0] pcol_next;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Sequencer: six sines, the matrix build, or the nine point products.
  always_comb begin
    state_next = state;
    sk_next = sk;
    hcnt_next = hcnt;
    cnt_next = cnt;
    prow_next = prow;
    pcol_next = pcol;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.in_load = 1'b1;
          if (operation) begin
            sk_next = '0;
            state_next = S_ANG;
          end else begin
            prow_next = '0;
            pcol_next = '0;
            state_next = S_PMUL;
          end
        end
      end
      S_ANG: begin
        cmd.ang_load = 1'b1;
        cmd.sin_idx = sk;
        state_next = S_FK;
      end
      S_FK: begin
        cmd.mul_go = 1'b1;
        cmd.opsel = OPS_FK;
        cmd.post = POST_X;
        state_next = S_XW;
      end
      S_XW: state_next = S_XX;
      S_XX: begin
        cmd.mul_go = 1'b1;
        cmd.opsel = OPS_XX;
        cmd.post = POST_X2;
        cmd.t_init = 1'b1;
        hcnt_next = '0;
        state_next = S_X2W;
      end
      S_X2W: state_next = S_HMUL;
      S_HMUL: begin
        cmd.mul_go = 1'b1;
        cmd.opsel = OPS_X2T;
        cmd.post = POST_DIV;
        cmd.hstep = hcnt;
        state_next = S_HW;
      end
      S_HW: state_next = S_DIVW;
      S_DIVW: begin
        if (stat.div_done) begin
          if (hcnt == HORNER_LAST) begin
            state_next = S_SMUL;
          end else begin
            hcnt_next = hcnt + 1'b1;
            state_next = S_HMUL;
          end
        end
      end
      S_SMUL: begin
        cmd.mul_go = 1'b1;
        cmd.opsel = OPS_XT;
        cmd.post = POST_SIN;
        cmd.sin_idx = sk;
        state_next = S_SW;
      end
      S_SW: begin
        if (sk == SIN_LAST) begin
          cnt_next = '0;
          state_next = S_MOP;
        end else begin
          sk_next = sk + 1'b1;
          state_next = S_ANG;
        end
      end
      S_MOP: begin
        cmd.mul_go = 1'b1;
        cmd.opsel = OPS_VAL;
        cmd.post = POST_MAT;
        cmd.mop_idx = cnt;
        if (cnt == MOP_LAST) begin
          state_next = S_MDRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MDRAIN: state_next = S_IDLE;
      S_PMUL: begin
        cmd.mul_go = 1'b1;
        cmd.opsel = OPS_PT;
        cmd.post = POST_PT;
        cmd.prow = prow;
        cmd.pcol = pcol;
        if (pcol == AXIS_LAST) begin
          pcol_next = '0;
          if (prow == AXIS_LAST) begin
            state_next = S_PDRAIN;
          end else begin
            prow_next = prow + 1'b1;
          end
        end else begin
          pcol_next = pcol + 1'b1;
        end
      end
      S_PDRAIN: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, counters and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sk <= '0;
      hcnt <= '0;
      cnt <= '0;
      prow <= '0;
      pcol <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sk <= sk_next;
      hcnt <= hcnt_next;
      cnt <= cnt_next;
      prow <= prow_next;
      pcol <= pcol_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### src/lidar_point_georeference.sv
`timescale 1ns / 1ps
`default_nettype none
// Lidar point georeference block.
// Input channel (in_valid / in_stall): an item with operation 1 loads a pose
// (roll, pitch, yaw in 0.01 degree and a north/east/down offset in mm); an
// item with operation 0 is a body-frame point in mm. An item is taken when
// in_valid is high and in_stall is low; one item is worked on at a time.
// Output channel (out_valid / out_stall): each point item gives one result
// item with ned_x, ned_y, ned_z, saturated to 32 bits. Pose items give none.
// A point runs nine products on the shared multiplier, a drain step and a
// step that loads the output register before the next item is accepted.
// A pose runs six sines (five Horner steps each, each step with a
// reciprocal-multiply divide), then 15 matrix products on the same multiplier
// and a drain step.
// The output register holds a result while out_stall is high; the next point
// may be accepted meanwhile and waits in its last cycle until it is taken.
// Reset clears the stored matrix and offset to zero, so points before any
// pose return zero, and leaves both channels empty.
module lidar_point_georeference (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               operation,
  input  wire logic signed [15:0] roll_angle,
  input  wire logic signed [15:0] pitch_angle,
  input  wire logic signed [16:0] yaw_angle,
  input  wire logic signed [31:0] offset_north,
  input  wire logic signed [31:0] offset_east,
  input  wire logic signed [31:0] offset_down,
  input  wire logic signed [23:0] body_x,
  input  wire logic signed [23:0] body_y,
  input  wire logic signed [23:0] body_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      ned_x,
  output logic signed [31:0]      ned_y,
  output logic signed [31:0]      ned_z
);
  import lpg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  lpg_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .roll_angle   (roll_angle),
    .pitch_angle  (pitch_angle),
    .yaw_angle    (yaw_angle),
    .offset_north (offset_north),
    .offset_east  (offset_east),
    .offset_down  (offset_down),
    .body_x       (body_x),
    .body_y       (body_y),
    .body_z       (body_z),
    .ned_x        (ned_x),
    .ned_y        (ned_y),
    .ned_z        (ned_z)
  );

endmodule
`default_nettype wire

### src/lpg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_point_georeference_assert.svh"
module lpg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] ned_x,
  input wire logic signed [31:0] ned_y,
  input wire logic signed [31:0] ned_z
);

  // After reset both channels are empty and the block is ready.
  `LPG_ASSERT(a_reset_idle, rst |=> !out_valid && !in_stall, "not idle after reset")

  // An accepted item always occupies the block in the next cycle.
  `LPG_ASSERT_RUN(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "no busy after item")

  // A result only appears at the end of work on an item.
  `LPG_ASSERT_RUN(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result while idle")

  // A stalled result stays and holds its value.
  `LPG_ASSERT_RUN(a_out_hold, out_valid && out_stall |=> out_valid && $stable(ned_x) &&
    $stable(ned_y) && $stable(ned_z), "stalled result changed")

endmodule

bind lidar_point_georeference lpg_checker u_chk (.*);
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic signed [15:0] roll_angle = '0;
  logic signed [15:0] pitch_angle = '0;
  logic signed [16:0] yaw_angle = '0;
  logic signed [31:0] offset_north = '0;
  logic signed [31:0] offset_east = '0;
  logic signed [31:0] offset_down = '0;
  logic signed [23:0] body_x = '0;
  logic signed [23:0] body_y = '0;
  logic signed [23:0] body_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] ned_x, ned_y, ned_z;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_POSE = 1'b1;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } ned_t;

  // Predicted pose state of the block.
  longint pose_mat[9];
  longint pose_ofs[3];
  ned_t ned_queue[$];

  int errors = 0;
  int n_points = 0;
  int n_poses = 0;
  int n_results = 0;
  int idle_cycles = 0;

  lidar_point_georeference dut (.*);

  always #2 clk = ~clk;

  // Quarter-wave sine in Q16 by a truncating Horner series in Q30.
  function automatic longint quarter_sine(longint f);
    longint unsigned x, x2, t;
    longint unsigned dv[5];
    dv = '{110, 72, 42, 20, 6};
    x = f * 187403;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[i];
    return longint'((((x * t) >> 30) + 8192) >> 14);
  endfunction

  function automatic longint sine_cdeg(longint a);
    longint r, q, f, v;
    r = a % 36000;
    if (r < 0) r += 36000;
    q = r / 9000;
    f = r % 9000;
    v = quarter_sine((q % 2 == 1) ? 9000 - f : f);
    return (q >= 2) ? -v : v;
  endfunction

  // Rounded half up shift; arithmetic shift floors.
  function automatic longint round_q(longint p, int sh);
    return (p + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_q(a * b, 16);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  // Builds the direction cosine matrix and stores the offset.
  task automatic load_pose(longint ra, longint pa, longint ya, longint n, longint e,
                           longint d);
    longint sr, cr, sp, cp, sy, cy, spsr, spcr;
    longint m[9];
    sr = sine_cdeg(ra); cr = sine_cdeg(ra + 9000);
    sp = sine_cdeg(pa); cp = sine_cdeg(pa + 9000);
    sy = sine_cdeg(ya); cy = sine_cdeg(ya + 9000);
    spsr = qmul(sp, sr);
    spcr = qmul(sp, cr);
    m[0] = qmul(cy, cp);
    m[1] = -qmul(sy, cr) + qmul(cy, spsr);
    m[2] = qmul(sy, sr) + qmul(cy, spcr);
    m[3] = qmul(sy, cp);
    m[4] = qmul(cy, cr) + qmul(sy, spsr);
    m[5] = qmul(sy, spcr) - qmul(cy, sr);
    m[6] = -sp;
    m[7] = qmul(cp, sr);
    m[8] = qmul(cp, cr);
    for (int i = 0; i < 9; i++) pose_mat[i] = clamp(m[i], -131072, 131071);
    pose_ofs = '{n, e, d};
  endtask

  function automatic ned_t transform_point(longint bx, longint by, longint bz);
    longint v[3];
    ned_t r;
    for (int i = 0; i < 3; i++)
      v[i] = clamp(round_q(pose_mat[3*i] * bx + pose_mat[3*i+1] * by + pose_mat[3*i+2] * bz,
                           16) + pose_ofs[i], -64'sd2147483648, 64'sd2147483647);
    r.x = 32'(v[0]); r.y = 32'(v[1]); r.z = 32'(v[2]);
    return r;
  endfunction

  // Sends one item, with a random gap in front of some of them.
  int burst_left = 0;
  task automatic send_item(logic op, logic [15:0] ra, logic [15:0] pa, logic [16:0] ya,
                           logic [31:0] n, logic [31:0] e, logic [31:0] d,
                           logic [23:0] bx, logic [23:0] by, logic [23:0] bz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 30));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    operation <= op;
    roll_angle <= ra; pitch_angle <= pa; yaw_angle <= ya;
    offset_north <= n; offset_east <= e; offset_down <= d;
    body_x <= bx; body_y <= by; body_z <= bz;
    do @(posedge clk); while (in_stall);
    if (op == OP_POSE) begin
      load_pose(longint'($signed(ra)), longint'($signed(pa)), longint'($signed(ya)),
                longint'($signed(n)), longint'($signed(e)), longint'($signed(d)));
      n_poses++;
    end else begin
      ned_queue.push_back(transform_point(longint'($signed(bx)), longint'($signed(by)),
                                          longint'($signed(bz))));
      n_points++;
    end
  endtask

  task automatic send_pose(logic [15:0] ra, logic [15:0] pa, logic [16:0] ya,
                           logic [31:0] n, logic [31:0] e, logic [31:0] d);
    send_item(OP_POSE, ra, pa, ya, n, e, d, 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic send_point(logic [23:0] bx, logic [23:0] by, logic [23:0] bz);
    send_item(OP_POINT, 16'($urandom), 16'($urandom), 17'($urandom), $urandom, $urandom,
              $urandom, bx, by, bz);
  endtask

  // Receiver stall pattern: runs of stall and of free flow, sometimes none at all.
  initial begin
    forever begin
      out_stall <= ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (ned_queue.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d", ned_x, ned_y, ned_z);
        errors++;
      end else begin
        ned_t w;
        w = ned_queue.pop_front();
        if (ned_x !== w.x) begin
          $error("ned_x expected %0d actual %0d", w.x, ned_x); errors++;
        end
        if (ned_y !== w.y) begin
          $error("ned_y expected %0d actual %0d", w.y, ned_y); errors++;
        end
        if (ned_z !== w.z) begin
          $error("ned_z expected %0d actual %0d", w.z, ned_z); errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Points before any pose give the zero offset.
  task automatic test_reset_state();
    send_point(24'h7FFFFF, 24'h800000, 24'h123456);
    send_point(24'h0, 24'h0, 24'h0);
  endtask

  // Field extremes, quadrant edges, out-of-range angles and saturation.
  task automatic test_directed();
    send_pose(16'd0, 16'd0, 17'd0, 32'd1000, -32'sd2000, 32'd3000);
    send_point(24'h7FFFFF, 24'h800000, 24'h000001);
    send_pose(16'd9000, -16'sd9000, 17'd36000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFF0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_pose(16'd18000, -16'sd18000, -17'sd36000, 32'h80000000, 32'h7FFFFFFF, 32'd0);
    send_point(24'h800000, 24'h7FFFFF, 24'h000000);
    send_pose(16'h7FFF, 16'h8000, 17'h0FFFF, 32'hFFFFFFFF, 32'd1, 32'h80000000);
    send_point(24'h555555, 24'hAAAAAA, 24'h7FFFFF);
    send_pose(16'h8000, 16'h7FFF, 17'h10000, 32'd0, 32'd0, 32'd0);
    send_point(24'h0FFFFF, 24'hF00000, 24'h800000);
    send_pose(16'd4500, 16'd2700, 17'd27000, 32'd5, 32'd6, 32'd7);
    send_point(24'd1000, 24'd2000, 24'd3000);
  endtask

  function automatic logic [16:0] rand_angle(int span);
    case ($urandom_range(0, 5))
      0: return 17'($urandom);
      1: return 17'(9000 * $urandom_range(0, 8) - 36000);
      default: return 17'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  function automatic logic [23:0] rand_body();
    return ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000) - 100000);
  endfunction

  // Random flights: mostly points under a pose, a new pose now and then.
  task automatic test_random();
    for (int i = 0; i < 780; i++) begin
      if ($urandom_range(0, 14) == 0)
        send_pose(16'(rand_angle(18000)), 16'(rand_angle(18000)), rand_angle(36000),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000000) - 1000000,
                  $urandom, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400000));
      else
        send_point(rand_body(), rand_body(), rand_body());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (ned_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d points and %0d poses, checked %0d results.", n_points, n_poses,
             n_results);
    $display("Covered reset state, angle extremes and wraparound, and saturated outputs.");
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
